// ----- rtl/c2fm_pkg.sv -----
// Shared types and constants for the C2 interface frame master.
`timescale 1ns / 1ps
package c2fm_pkg;

  localparam int unsigned TIMER_BITS = 20;
  localparam int unsigned LIM_W      = 33;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  localparam logic [2:0] REG_LOW_TICKS   = 3'd0;
  localparam logic [2:0] REG_HIGH_TICKS  = 3'd1;
  localparam logic [2:0] REG_RST_LOW     = 3'd2;
  localparam logic [2:0] REG_RST_RECOVER = 3'd3;
  localparam logic [2:0] REG_WAIT_LIMIT  = 3'd4;

  localparam logic [2:0] OP_ADDR_WRITE = 3'd0;
  localparam logic [2:0] OP_ADDR_READ  = 3'd1;
  localparam logic [2:0] OP_DATA_WRITE = 3'd2;
  localparam logic [2:0] OP_DATA_READ  = 3'd3;
  localparam logic [2:0] OP_RESET      = 3'd4;

  typedef struct packed {
    logic [15:0] low_ticks;
    logic [15:0] high_ticks;
    logic [19:0] reset_low_ticks;
    logic [19:0] reset_recover_ticks;
    logic [15:0] wait_limit;
  } c2fm_cfg_t;

  typedef struct packed {
    logic       start_req;
    logic [2:0] opcode;
    logic [7:0] write_byte;
    logic       data_pin_in;
  } c2fm_item_t;

  typedef struct packed {
    logic       clock_pin;
    logic       data_drive_enable;
    logic       data_pin_out;
    logic       busy_res;
    logic       frame_done;
    logic       ack_ok;
    logic [7:0] read_byte;
  } c2fm_res_t;

endpackage

// ----- rtl/c2_interface_frame_master_core.sv -----
// Top level of the C2 interface frame master: item registers, sequencer, registers.
// Result path: the accepted item is held in the input register, and its result in the result register.
// Throughput: one item per cycle while no result waits; the sequencer steps once per item in a single pass.
// A waiting result stalls the sequencer; one more item can wait in the input register.
// Reset: synchronous active-low rst_n clears both stage valids and the frame state
// and loads the timing registers with their defaults.
`timescale 1ns / 1ps
module c2_interface_frame_master_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_start_req,
  input  logic [2:0]                   in_opcode,
  input  logic [7:0]                   in_write_byte,
  input  logic                         in_data_pin_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_clock_pin,
  output logic                         out_data_drive_enable,
  output logic                         out_data_pin_out,
  output logic                         out_busy_res,
  output logic                         out_frame_done,
  output logic                         out_ack_ok,
  output logic [7:0]                   out_read_byte,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [c2fm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [c2fm_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [c2fm_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import c2fm_pkg::*;

  c2fm_cfg_t  cfg;
  c2fm_item_t item_r;
  c2fm_res_t  res;
  c2fm_res_t  res_r;
  logic       item_vld_r;
  logic       out_vld_r;
  logic       step;

  assign step     = item_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~item_vld_r | step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_ready) item_vld_r <= in_valid;
      if (step) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.start_req   <= in_start_req;
      item_r.opcode      <= in_opcode;
      item_r.write_byte  <= in_write_byte;
      item_r.data_pin_in <= in_data_pin_in;
    end
    if (step) res_r <= res;
  end

  c2fm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  c2fm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_valid             = out_vld_r;
  assign out_clock_pin         = res_r.clock_pin;
  assign out_data_drive_enable = res_r.data_drive_enable;
  assign out_data_pin_out      = res_r.data_pin_out;
  assign out_busy_res          = res_r.busy_res;
  assign out_frame_done        = res_r.frame_done;
  assign out_ack_ok            = res_r.ack_ok;
  assign out_read_byte         = res_r.read_byte;

endmodule

// ----- rtl/c2fm_cfg.sv -----
// APB register bank holding the pulse timing and acknowledge wait limit.
`timescale 1ns / 1ps
module c2fm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [c2fm_pkg::CFG_AW-1:0]  paddr,
  input  logic [c2fm_pkg::CFG_DW-1:0]  pwdata,
  output logic [c2fm_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output c2fm_pkg::c2fm_cfg_t          cfg
);
  import c2fm_pkg::*;

  c2fm_cfg_t  cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[CFG_AW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_ticks           <= 16'd30;
      cfg_r.high_ticks          <= 16'd50;
      cfg_r.reset_low_ticks     <= 20'd2500;
      cfg_r.reset_recover_ticks <= 20'd300;
      cfg_r.wait_limit          <= 16'd600;
    end else if (wr_en) begin
      case (idx)
        REG_LOW_TICKS:   cfg_r.low_ticks           <= pwdata[15:0];
        REG_HIGH_TICKS:  cfg_r.high_ticks          <= pwdata[15:0];
        REG_RST_LOW:     cfg_r.reset_low_ticks     <= pwdata[19:0];
        REG_RST_RECOVER: cfg_r.reset_recover_ticks <= pwdata[19:0];
        REG_WAIT_LIMIT:  cfg_r.wait_limit          <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LOW_TICKS:   prdata = {16'd0, cfg_r.low_ticks};
      REG_HIGH_TICKS:  prdata = {16'd0, cfg_r.high_ticks};
      REG_RST_LOW:     prdata = {12'd0, cfg_r.reset_low_ticks};
      REG_RST_RECOVER: prdata = {12'd0, cfg_r.reset_recover_ticks};
      REG_WAIT_LIMIT:  prdata = {16'd0, cfg_r.wait_limit};
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- rtl/c2fm_seq.sv -----
// Pin-level frame sequencer: one tick of state update per item.
`timescale 1ns / 1ps
module c2fm_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  c2fm_pkg::c2fm_item_t item,
  input  c2fm_pkg::c2fm_cfg_t  cfg,
  output c2fm_pkg::c2fm_res_t  res
);
  import c2fm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_INS, PH_LEN, PH_WBITS,
    PH_RBITS, PH_WAIT, PH_STOP, PH_RST_LOW, PH_RST_HIGH
  } phase_t;

  localparam logic [LIM_W-1:0] TIMER_CAP = LIM_W'(64'd1 << TIMER_BITS);

  phase_t                phase_r, phase_nxt;
  logic [2:0]            kind_r, kind_nxt;
  logic [TIMER_BITS-1:0] tick_r, tick_nxt;
  logic [3:0]            bcnt_r, bcnt_nxt;
  logic [15:0]           wcnt_r, wcnt_nxt;
  logic [7:0]            sbyte_r, sbyte_nxt;
  logic                  ack_r, ack_nxt;
  logic [1:0]            drive_r, drive_nxt;
  logic                  clkhi_r, clkhi_nxt;

  always_comb begin
    logic [LIM_W-1:0] raw;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] nxt_tick;
    logic             over;
    logic             done;
    logic [15:0]      wl;

    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    tick_nxt  = tick_r;
    bcnt_nxt  = bcnt_r;
    wcnt_nxt  = wcnt_r;
    sbyte_nxt = sbyte_r;
    ack_nxt   = ack_r;
    drive_nxt = drive_r;
    clkhi_nxt = clkhi_r;
    done      = 1'b0;

    if (phase_r == PH_IDLE && item.start_req && item.opcode <= OP_RESET) begin
      kind_nxt  = item.opcode;
      tick_nxt  = '0;
      bcnt_nxt  = '0;
      wcnt_nxt  = '0;
      clkhi_nxt = 1'b0;
      ack_nxt   = !(item.opcode == OP_DATA_WRITE || item.opcode == OP_DATA_READ);
      sbyte_nxt = (item.opcode == OP_ADDR_WRITE || item.opcode == OP_DATA_WRITE) ?
                  item.write_byte : 8'd0;
      phase_nxt = (item.opcode == OP_RESET) ? PH_RST_LOW : PH_START;
    end

    res.busy_res          = phase_nxt != PH_IDLE;
    res.clock_pin         = (phase_nxt == PH_IDLE || phase_nxt == PH_RST_HIGH) ? 1'b1 :
                            (phase_nxt == PH_RST_LOW) ? 1'b0 : clkhi_nxt;
    res.data_drive_enable = drive_nxt[0];
    res.data_pin_out      = drive_nxt[1];

    // half-period timer
    case (phase_nxt)
      PH_RST_LOW:  raw = LIM_W'(cfg.reset_low_ticks);
      PH_RST_HIGH: raw = LIM_W'(cfg.reset_recover_ticks);
      default:     raw = clkhi_nxt ? LIM_W'(cfg.high_ticks) : LIM_W'(cfg.low_ticks);
    endcase
    lim      = (raw == '0) ? LIM_W'(1) : ((raw > TIMER_CAP) ? TIMER_CAP : raw);
    nxt_tick = LIM_W'(tick_nxt) + LIM_W'(1);
    over     = nxt_tick >= lim;
    wl       = (cfg.wait_limit == 16'd0) ? 16'd1 : cfg.wait_limit;

    if (phase_nxt != PH_IDLE) begin
      tick_nxt = over ? '0 : nxt_tick[TIMER_BITS-1:0];
    end

    if (phase_nxt == PH_RST_LOW) begin
      if (over) phase_nxt = PH_RST_HIGH;
    end else if (phase_nxt == PH_RST_HIGH) begin
      if (over) begin
        ack_nxt   = 1'b1;
        phase_nxt = PH_IDLE;
        clkhi_nxt = 1'b0;
        done      = 1'b1;
      end
    end else if (phase_nxt != PH_IDLE) begin
      if (!clkhi_nxt) begin
        if (over) clkhi_nxt = 1'b1;
      end else if (over) begin
        // end of a pulse; every path leaves the clock low with the timer at zero
        clkhi_nxt = 1'b0;
        case (phase_nxt)
          PH_START: begin
            phase_nxt = PH_INS;
            bcnt_nxt  = '0;
            drive_nxt = {~kind_nxt[0], 1'b1};
          end
          PH_INS: begin
            bcnt_nxt = bcnt_nxt + 4'd1;
            if (bcnt_nxt < 4'd2) begin
              drive_nxt = {~kind_nxt[1], 1'b1};
            end else begin
              bcnt_nxt = '0;
              if (kind_nxt == OP_ADDR_WRITE) begin
                phase_nxt = PH_WBITS;
                drive_nxt = {sbyte_nxt[0], 1'b1};
              end else if (kind_nxt == OP_ADDR_READ) begin
                phase_nxt = PH_RBITS;
                drive_nxt = 2'b00;
                sbyte_nxt = '0;
              end else begin
                phase_nxt = PH_LEN;
                drive_nxt = 2'b01;
              end
            end
          end
          PH_LEN: begin
            bcnt_nxt = bcnt_nxt + 4'd1;
            if (bcnt_nxt < 4'd2) begin
              drive_nxt = 2'b01;
            end else begin
              bcnt_nxt = '0;
              if (kind_nxt == OP_DATA_WRITE) begin
                phase_nxt = PH_WBITS;
                drive_nxt = {sbyte_nxt[0], 1'b1};
              end else begin
                phase_nxt = PH_WAIT;
                drive_nxt = 2'b00;
                wcnt_nxt  = '0;
              end
            end
          end
          PH_WBITS: begin
            bcnt_nxt = bcnt_nxt + 4'd1;
            if (bcnt_nxt < 4'd8) begin
              drive_nxt = {sbyte_nxt[bcnt_nxt[2:0]], 1'b1};
            end else begin
              bcnt_nxt  = '0;
              drive_nxt = 2'b00;
              if (kind_nxt == OP_DATA_WRITE) begin
                phase_nxt = PH_WAIT;
                wcnt_nxt  = '0;
              end else begin
                phase_nxt = PH_STOP;
              end
            end
          end
          PH_RBITS: begin
            sbyte_nxt = {item.data_pin_in, sbyte_nxt[7:1]};
            bcnt_nxt  = bcnt_nxt + 4'd1;
            if (bcnt_nxt >= 4'd8) begin
              bcnt_nxt  = '0;
              phase_nxt = PH_STOP;
            end
          end
          PH_WAIT: begin
            if (item.data_pin_in) begin
              ack_nxt = 1'b1;
              if (kind_nxt == OP_DATA_READ) begin
                phase_nxt = PH_RBITS;
                bcnt_nxt  = '0;
                sbyte_nxt = '0;
              end else begin
                phase_nxt = PH_STOP;
              end
            end else begin
              wcnt_nxt = wcnt_nxt + 16'd1;
              if (wcnt_nxt >= wl || wcnt_nxt == 16'd0) begin
                ack_nxt = 1'b0;
                if (kind_nxt == OP_DATA_READ) begin
                  // timed-out read ends without a stop pulse
                  sbyte_nxt = '0;
                  phase_nxt = PH_IDLE;
                  done      = 1'b1;
                end else begin
                  phase_nxt = PH_STOP;
                end
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        endcase
      end
    end

    res.frame_done = done;
    res.ack_ok     = done & ack_nxt;
    res.read_byte  = (done && (kind_nxt == OP_ADDR_READ || kind_nxt == OP_DATA_READ)) ?
                     sbyte_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= '0;
      tick_r  <= '0;
      bcnt_r  <= '0;
      wcnt_r  <= '0;
      sbyte_r <= '0;
      ack_r   <= 1'b0;
      drive_r <= 2'b00;
      clkhi_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      tick_r  <= tick_nxt;
      bcnt_r  <= bcnt_nxt;
      wcnt_r  <= wcnt_nxt;
      sbyte_r <= sbyte_nxt;
      ack_r   <= ack_nxt;
      drive_r <= drive_nxt;
      clkhi_r <= clkhi_nxt;
    end
  end

endmodule
